/* rtl/dcf_pkg.sv */
// shared types, event codes and pulse windows for the dcf77 time code decoder
package dcf_pkg;

    localparam int unsigned PulseW = 12;
    localparam int unsigned EventW = 3;
    localparam int unsigned PosW   = 6;

    localparam logic [EventW-1:0] EV_NONE    = 3'd0;
    localparam logic [EventW-1:0] EV_ZERO    = 3'd1;
    localparam logic [EventW-1:0] EV_ONE     = 3'd2;
    localparam logic [EventW-1:0] EV_SECOND  = 3'd3;
    localparam logic [EventW-1:0] EV_MINUTE  = 3'd4;
    localparam logic [EventW-1:0] EV_INVALID = 3'd5;

    // pulse length windows in ms, inclusive
    localparam logic [PulseW-1:0] ZERO_LO   = 12'd70;
    localparam logic [PulseW-1:0] ZERO_HI   = 12'd130;
    localparam logic [PulseW-1:0] ONE_LO    = 12'd170;
    localparam logic [PulseW-1:0] ONE_HI    = 12'd230;
    localparam logic [PulseW-1:0] SECOND_LO = 12'd900;
    localparam logic [PulseW-1:0] SECOND_HI = 12'd1100;
    localparam logic [PulseW-1:0] MINUTE_LO = 12'd1900;
    localparam logic [PulseW-1:0] MINUTE_HI = 12'd2100;

    // bit positions in the minute frame
    localparam logic [PosW-1:0] POS_MINUTE_FIRST  = 6'd21;
    localparam logic [PosW-1:0] POS_MINUTE_LAST   = 6'd27;
    localparam logic [PosW-1:0] POS_PAR_MINUTE    = 6'd28;
    localparam logic [PosW-1:0] POS_HOUR_FIRST    = 6'd29;
    localparam logic [PosW-1:0] POS_HOUR_LAST     = 6'd34;
    localparam logic [PosW-1:0] POS_PAR_HOUR      = 6'd35;
    localparam logic [PosW-1:0] POS_DAY_FIRST     = 6'd36;
    localparam logic [PosW-1:0] POS_DAY_LAST      = 6'd41;
    localparam logic [PosW-1:0] POS_WEEKDAY_FIRST = 6'd42;
    localparam logic [PosW-1:0] POS_WEEKDAY_LAST  = 6'd44;
    localparam logic [PosW-1:0] POS_MONTH_FIRST   = 6'd45;
    localparam logic [PosW-1:0] POS_MONTH_LAST    = 6'd49;
    localparam logic [PosW-1:0] POS_YEAR_FIRST    = 6'd50;
    localparam logic [PosW-1:0] POS_YEAR_LAST     = 6'd57;
    localparam logic [PosW-1:0] POS_PAR_DATE      = 6'd58;
    localparam logic [PosW-1:0] POS_MAX           = 6'd63;

    localparam logic [11:0] YEAR_BASE = 12'd2000;

    localparam logic [5:0] RESET_DAY   = 6'd1;
    localparam logic [4:0] RESET_MONTH = 5'd1;
    localparam logic [7:0] RESET_YEAR  = 8'd17;

    typedef struct packed {
        logic              signal_level;
        logic [PulseW-1:0] pulse_time_ms;
    } t_dcf_in;

    typedef struct packed {
        logic [EventW-1:0] event_code;
        logic              time_committed;
        logic              is_synced;
        logic [6:0]        out_minute;
        logic [5:0]        out_hour;
        logic [5:0]        out_day;
        logic [2:0]        out_weekday;
        logic [4:0]        out_month;
        logic [11:0]       out_year;
    } t_dcf_out;

    // state the classifier needs from the field decoder
    typedef struct packed {
        logic prev_level;
        logic parity_fault;
    } t_dcf_status;

    // bcd weight of bit index within a field
    function automatic logic [7:0] bcd_weight(input logic [2:0] idx);
        logic [7:0] w;
        unique case (idx)
            3'd0: w = 8'd1;
            3'd1: w = 8'd2;
            3'd2: w = 8'd4;
            3'd3: w = 8'd8;
            3'd4: w = 8'd10;
            3'd5: w = 8'd20;
            3'd6: w = 8'd40;
            3'd7: w = 8'd80;
            default: w = 8'd0;
        endcase
        return w;
    endfunction

endpackage

/* rtl/dcf_classify.sv */
// edge detection, pulse window and parity fault classification of one sample
module dcf_classify (
    input  dcf_pkg::t_dcf_in              i_item,
    input  dcf_pkg::t_dcf_status          i_status,
    output logic [dcf_pkg::EventW-1:0]    o_event
);

    logic                       rising;
    logic                       falling;
    logic [dcf_pkg::PulseW-1:0] t;

    assign t       = i_item.pulse_time_ms;
    assign rising  = !i_status.prev_level && i_item.signal_level;
    assign falling = i_status.prev_level && !i_item.signal_level;

    always_comb begin
        o_event = dcf_pkg::EV_NONE;
        priority if (i_status.parity_fault) begin
            o_event = dcf_pkg::EV_INVALID;
        end else if (rising) begin
            priority if (t >= dcf_pkg::ZERO_LO && t <= dcf_pkg::ZERO_HI) begin
                o_event = dcf_pkg::EV_ZERO;
            end else if (t >= dcf_pkg::ONE_LO && t <= dcf_pkg::ONE_HI) begin
                o_event = dcf_pkg::EV_ONE;
            end else begin
                o_event = dcf_pkg::EV_INVALID;
            end
        end else if (falling) begin
            priority if (t >= dcf_pkg::SECOND_LO && t <= dcf_pkg::SECOND_HI) begin
                o_event = dcf_pkg::EV_SECOND;
            end else if (t >= dcf_pkg::MINUTE_LO && t <= dcf_pkg::MINUTE_HI) begin
                o_event = dcf_pkg::EV_MINUTE;
            end else begin
                o_event = dcf_pkg::EV_INVALID;
            end
        end else begin
            o_event = dcf_pkg::EV_NONE;
        end
    end

endmodule

/* rtl/dcf_fields.sv */
// decoder state: bit gathering, parity, sync and committed time
module dcf_fields (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_level,
    input  logic [dcf_pkg::EventW-1:0]    i_event,
    output dcf_pkg::t_dcf_status          o_status,
    output dcf_pkg::t_dcf_out             o_result
);

    logic                     r_prev_level, n_prev_level;
    logic                     r_held_bit, n_held_bit;
    logic [dcf_pkg::PosW-1:0] r_pos, n_pos;
    logic                     r_ones, n_ones;
    logic                     r_fault, n_fault;
    logic                     r_synced, n_synced;
    logic [6:0]               r_p_minute, n_p_minute;
    logic [5:0]               r_p_hour, n_p_hour;
    logic [5:0]               r_p_day, n_p_day;
    logic [2:0]               r_p_weekday, n_p_weekday;
    logic [4:0]               r_p_month, n_p_month;
    logic [7:0]               r_p_year, n_p_year;
    logic [6:0]               r_h_minute, n_h_minute;
    logic [5:0]               r_h_hour, n_h_hour;
    logic [5:0]               r_h_day, n_h_day;
    logic [2:0]               r_h_weekday, n_h_weekday;
    logic [4:0]               r_h_month, n_h_month;
    logic [7:0]               r_h_year, n_h_year;
    logic                     n_committed;

    // values after storing the held bit at the current position
    logic                     s_ones, s_fault;
    logic [6:0]               s_minute;
    logic [5:0]               s_hour, s_day;
    logic [2:0]               s_weekday;
    logic [4:0]               s_month;
    logic [7:0]               s_year;
    logic                     is_parity_pos;
    logic [dcf_pkg::PosW-1:0] off;
    logic [7:0]               w;

    assign is_parity_pos = (r_pos == dcf_pkg::POS_PAR_MINUTE) ||
                           (r_pos == dcf_pkg::POS_PAR_HOUR) ||
                           (r_pos == dcf_pkg::POS_PAR_DATE);

    always_comb begin
        s_ones    = r_ones;
        s_fault   = r_fault;
        s_minute  = r_p_minute;
        s_hour    = r_p_hour;
        s_day     = r_p_day;
        s_weekday = r_p_weekday;
        s_month   = r_p_month;
        s_year    = r_p_year;
        off       = '0;
        w         = '0;
        if (is_parity_pos) begin
            if (r_ones != r_held_bit) begin
                s_fault = 1'b1;
            end
            s_ones = 1'b0;
        end else if (r_held_bit) begin
            if (r_pos >= dcf_pkg::POS_MINUTE_FIRST && r_pos <= dcf_pkg::POS_YEAR_LAST) begin
                s_ones = !r_ones;
            end
            priority if (r_pos >= dcf_pkg::POS_MINUTE_FIRST &&
                         r_pos <= dcf_pkg::POS_MINUTE_LAST) begin
                off      = r_pos - dcf_pkg::POS_MINUTE_FIRST;
                w        = dcf_pkg::bcd_weight(off[2:0]);
                s_minute = r_p_minute + w[6:0];
            end else if (r_pos >= dcf_pkg::POS_HOUR_FIRST &&
                         r_pos <= dcf_pkg::POS_HOUR_LAST) begin
                off    = r_pos - dcf_pkg::POS_HOUR_FIRST;
                w      = dcf_pkg::bcd_weight(off[2:0]);
                s_hour = r_p_hour + w[5:0];
            end else if (r_pos >= dcf_pkg::POS_DAY_FIRST &&
                         r_pos <= dcf_pkg::POS_DAY_LAST) begin
                off   = r_pos - dcf_pkg::POS_DAY_FIRST;
                w     = dcf_pkg::bcd_weight(off[2:0]);
                s_day = r_p_day + w[5:0];
            end else if (r_pos >= dcf_pkg::POS_WEEKDAY_FIRST &&
                         r_pos <= dcf_pkg::POS_WEEKDAY_LAST) begin
                off       = r_pos - dcf_pkg::POS_WEEKDAY_FIRST;
                w         = dcf_pkg::bcd_weight(off[2:0]);
                s_weekday = r_p_weekday + w[2:0];
            end else if (r_pos >= dcf_pkg::POS_MONTH_FIRST &&
                         r_pos <= dcf_pkg::POS_MONTH_LAST) begin
                off     = r_pos - dcf_pkg::POS_MONTH_FIRST;
                w       = dcf_pkg::bcd_weight(off[2:0]);
                s_month = r_p_month + w[4:0];
            end else if (r_pos >= dcf_pkg::POS_YEAR_FIRST &&
                         r_pos <= dcf_pkg::POS_YEAR_LAST) begin
                off    = r_pos - dcf_pkg::POS_YEAR_FIRST;
                w      = dcf_pkg::bcd_weight(off[2:0]);
                s_year = r_p_year + w;
            end else begin
                off = '0;
            end
        end
    end

    always_comb begin
        n_prev_level = i_level;
        n_held_bit   = r_held_bit;
        n_pos        = r_pos;
        n_ones       = r_ones;
        n_fault      = r_fault;
        n_synced     = r_synced;
        n_p_minute   = r_p_minute;
        n_p_hour     = r_p_hour;
        n_p_day      = r_p_day;
        n_p_weekday  = r_p_weekday;
        n_p_month    = r_p_month;
        n_p_year     = r_p_year;
        n_h_minute   = r_h_minute;
        n_h_hour     = r_h_hour;
        n_h_day      = r_h_day;
        n_h_weekday  = r_h_weekday;
        n_h_month    = r_h_month;
        n_h_year     = r_h_year;
        n_committed  = 1'b0;

        // a pending parity fault is consumed by this transaction
        if (r_fault) begin
            n_fault = 1'b0;
            n_ones  = 1'b0;
        end

        unique case (i_event)
            dcf_pkg::EV_ZERO: begin
                n_held_bit = 1'b0;
            end
            dcf_pkg::EV_ONE: begin
                n_held_bit = 1'b1;
            end
            dcf_pkg::EV_SECOND: begin
                n_ones      = s_ones;
                n_fault     = s_fault;
                n_p_minute  = s_minute;
                n_p_hour    = s_hour;
                n_p_day     = s_day;
                n_p_weekday = s_weekday;
                n_p_month   = s_month;
                n_p_year    = s_year;
                if (r_pos != dcf_pkg::POS_MAX) begin
                    n_pos = r_pos + 6'd1;
                end
            end
            dcf_pkg::EV_MINUTE: begin
                if (r_synced) begin
                    n_ones      = s_ones;
                    n_fault     = s_fault;
                    n_h_minute  = s_minute;
                    n_h_hour    = s_hour;
                    n_h_day     = s_day;
                    n_h_weekday = s_weekday;
                    n_h_month   = s_month;
                    n_h_year    = s_year;
                    n_committed = 1'b1;
                end else begin
                    n_synced = 1'b1;
                end
                n_pos       = '0;
                n_p_minute  = '0;
                n_p_hour    = '0;
                n_p_day     = '0;
                n_p_weekday = '0;
                n_p_month   = '0;
                n_p_year    = '0;
            end
            dcf_pkg::EV_INVALID: begin
                n_synced    = 1'b0;
                n_held_bit  = 1'b0;
                n_p_minute  = '0;
                n_p_hour    = '0;
                n_p_day     = '0;
                n_p_weekday = '0;
                n_p_month   = '0;
                n_p_year    = '0;
            end
            default: begin
                n_held_bit = r_held_bit;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b0;
            r_held_bit   <= 1'b0;
            r_pos        <= '0;
            r_ones       <= 1'b0;
            r_fault      <= 1'b0;
            r_synced     <= 1'b0;
            r_p_minute   <= '0;
            r_p_hour     <= '0;
            r_p_day      <= '0;
            r_p_weekday  <= '0;
            r_p_month    <= '0;
            r_p_year     <= '0;
            r_h_minute   <= '0;
            r_h_hour     <= '0;
            r_h_day      <= dcf_pkg::RESET_DAY;
            r_h_weekday  <= '0;
            r_h_month    <= dcf_pkg::RESET_MONTH;
            r_h_year     <= dcf_pkg::RESET_YEAR;
        end else if (i_step) begin
            r_prev_level <= n_prev_level;
            r_held_bit   <= n_held_bit;
            r_pos        <= n_pos;
            r_ones       <= n_ones;
            r_fault      <= n_fault;
            r_synced     <= n_synced;
            r_p_minute   <= n_p_minute;
            r_p_hour     <= n_p_hour;
            r_p_day      <= n_p_day;
            r_p_weekday  <= n_p_weekday;
            r_p_month    <= n_p_month;
            r_p_year     <= n_p_year;
            r_h_minute   <= n_h_minute;
            r_h_hour     <= n_h_hour;
            r_h_day      <= n_h_day;
            r_h_weekday  <= n_h_weekday;
            r_h_month    <= n_h_month;
            r_h_year     <= n_h_year;
        end
    end

    assign o_status.prev_level   = r_prev_level;
    assign o_status.parity_fault = r_fault;

    always_comb begin
        o_result.event_code     = i_event;
        o_result.time_committed = n_committed;
        o_result.is_synced      = n_synced;
        o_result.out_minute     = n_h_minute;
        o_result.out_hour       = n_h_hour;
        o_result.out_day        = n_h_day;
        o_result.out_weekday    = n_h_weekday;
        o_result.out_month      = n_h_month;
        o_result.out_year       = dcf_pkg::YEAR_BASE + {4'd0, n_h_year};
    end

endmodule

/* rtl/dcf77_time_code_decoder.sv */
// dcf77 time code decoder top level: input register, decode step, result register
//
// Accepts one 10 ms sample per clock cycle while not stalled and returns one
// result per sample. Each sample passes from the input register through the
// decode step; the result register holds its result while stalled. A sample
// sits in the input register; when the result register is free or being
// drained, the sample is classified (edge and pulse window), the bit, parity
// and sync state is updated and the result is registered in the same cycle.
// The input side keeps accepting while a result waits, until the input
// register is also full.
// Committed time starts at day 1, month 1, year 2017 after reset.
module dcf77_time_code_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dcf_pkg::t_dcf_in   i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dcf_pkg::t_dcf_out  o_out_data
);

    logic                           r_in_valid;
    dcf_pkg::t_dcf_in               r_in;
    logic                           r_out_valid;
    dcf_pkg::t_dcf_out              r_out;
    logic                           step;
    logic [dcf_pkg::EventW-1:0]     event_code;
    dcf_pkg::t_dcf_status           status;
    dcf_pkg::t_dcf_out              result;

    // move the held sample through the decode step into the result register
    assign step       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step;

    dcf_classify u_classify (
        .i_item   (r_in),
        .i_status (status),
        .o_event  (event_code)
    );

    dcf_fields u_fields (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_level  (r_in.signal_level),
        .i_event  (event_code),
        .o_status (status),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
